FILE: design/brf_pkg.sv
// Shared types and constants for the byte ring FIFO with peek.
// Holds action codes, status codes, register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package brf_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;

  // Action codes carried by one input beat
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_REWIND = 3'd3,
    ACT_COMMIT = 3'd4,
    ACT_SETOFF = 3'd5,
    ACT_CLEAR  = 3'd6
  } brf_action_t;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLAMPED = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 1'b1;

  // Register reset values
  localparam logic [CNT_W-1:0] SIZE_RESET = 9'd256;

endpackage

`default_nettype wire

FILE: design/byte_ring_fifo_with_peek.sv
// Top level of the byte ring FIFO with read-ahead (peek) pointer.
// Depends on brf_pkg and brf_mod_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one action beat: push, pop,
//   peek, rewind peek, commit peek, set peek offset or clear. Each beat
//   yields exactly one result beat on the output channel (out_valid/
//   out_ready) with status, read byte, overwrite flag and the counts after
//   the action, plus the echoed request_last marker.
//   Bytes live in one DEPTH-entry synchronous RAM with a registered read;
//   the pointers and counts sit in registers.
//   The RAM is read as a beat is accepted; the update stage (S_EXEC) then
//   loads the result beat into the output register. Set peek offset first
//   waits in S_MOD while an iterative remainder unit runs the pointer wrap.
//   A new beat is not taken until the previous one has left the update
//   stage; a new beat is taken while a result waits in the output register.
//   Reset (rst_n low, synchronous) empties the ring, sets the size to 256
//   and disables overwrite; RAM contents are left as they are.
//   If the receiver stalls, the finished result holds in the output register
//   and the next beat waits in the update stage until the register drains.
//   Configuration (cfg_we/cfg_index/cfg_wdata) must be written only while
//   idle; the user is bound by this, as the block does not enforce it.
`default_nettype none

module byte_ring_fifo_with_peek #(
  parameter int unsigned DEPTH = 256
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Configuration write port
  input  wire                                  cfg_we,
  input  wire  [brf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [brf_pkg::CNT_W-1:0]            cfg_wdata,
  // Input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [brf_pkg::ACT_W-1:0]            in_action,
  input  wire  [brf_pkg::DATA_W-1:0]           in_write_data,
  input  wire  [brf_pkg::CNT_W-1:0]            in_offset_count,
  input  wire                                  in_request_last,
  // Result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [brf_pkg::STAT_W-1:0]           out_status,
  output logic [brf_pkg::DATA_W-1:0]           out_read_data,
  output logic                                 out_dropped_oldest,
  output logic [brf_pkg::CNT_W-1:0]            out_fill_count,
  output logic [brf_pkg::CNT_W-1:0]            out_peek_remaining,
  output logic [brf_pkg::CNT_W-1:0]            out_peeked_count,
  output logic                                 out_last
);

  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_MAX   = (1 << brf_pkg::CNT_W) - 1;
  localparam int unsigned DEPTH_CAP = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
  localparam int unsigned SUM_W     = ((PTR_W > brf_pkg::CNT_W) ? PTR_W : brf_pkg::CNT_W) + 1;
  localparam int unsigned CMP_W     = ((PTR_W + 1) > brf_pkg::CNT_W) ? (PTR_W + 1)
                                                                    : brf_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_EXEC
  } state_t;

  // Configuration registers
  logic [brf_pkg::CNT_W-1:0]  cfg_size_r;
  logic                       cfg_ovw_r;

  // Ring state
  logic [PTR_W-1:0]           head_r, head_nxt;
  logic [PTR_W-1:0]           tail_r, tail_nxt;
  logic [PTR_W-1:0]           peek_r, peek_nxt;
  logic [brf_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [brf_pkg::CNT_W-1:0]  pleft_r, pleft_nxt;

  // Byte store
  logic [brf_pkg::DATA_W-1:0] mem [DEPTH];
  logic [brf_pkg::DATA_W-1:0] rd_data_r;
  logic                       mem_we;

  // Held input beat
  state_t                     state_r;
  brf_pkg::brf_action_t       act_r;
  logic [brf_pkg::DATA_W-1:0] wdata_r;
  logic [brf_pkg::CNT_W-1:0]  off_r;
  logic                       clamp_r;
  logic                       last_r;

  // Output register
  logic                       out_valid_r;
  logic [brf_pkg::STAT_W-1:0] out_status_r;
  logic [brf_pkg::DATA_W-1:0] out_rdata_r;
  logic                       out_drop_r;
  logic [brf_pkg::CNT_W-1:0]  out_fill_r;
  logic [brf_pkg::CNT_W-1:0]  out_pleft_r;
  logic [brf_pkg::CNT_W-1:0]  out_peeked_r;
  logic                       out_last_r;

  // Step logic
  logic                       in_fire;
  logic                       exec_go;
  logic [brf_pkg::CNT_W-1:0]  rsize;
  logic                       off_over;
  logic [brf_pkg::CNT_W-1:0]  off_eff;
  logic                       mod_start;
  logic                       mod_done;
  logic [brf_pkg::CNT_W-1:0]  mod_rem;
  logic [SUM_W-1:0]           mod_dividend;
  logic [brf_pkg::STAT_W-1:0] status_c;
  logic [brf_pkg::DATA_W-1:0] rdata_c;
  logic                       drop_c;

  // Advance a pointer by one, wrapping at the ring size
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx,
                                                 input logic [brf_pkg::CNT_W-1:0] sz);
    logic [CMP_W-1:0] n;
    n = CMP_W'(idx) + CMP_W'(1);
    return (n >= CMP_W'(sz)) ? '0 : PTR_W'(n);
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Clamp the configured size into 1..DEPTH_CAP (DEPTH, at most 511)
  always_comb begin
    if (cfg_size_r == '0) begin
      rsize = brf_pkg::CNT_W'(1);
    end else if (cfg_size_r > brf_pkg::CNT_W'(DEPTH_CAP)) begin
      rsize = brf_pkg::CNT_W'(DEPTH_CAP);
    end else begin
      rsize = cfg_size_r;
    end
  end

  // Clamp the peek offset to the fill level and start the wrap
  assign off_over     = in_offset_count > fill_r;
  assign off_eff      = off_over ? fill_r : in_offset_count;
  assign mod_start    = in_fire && (in_action == brf_pkg::ACT_SETOFF);
  assign mod_dividend = SUM_W'(head_r) + SUM_W'(off_eff);

  brf_mod_unit #(
    .SUM_W (SUM_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (rsize),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= brf_pkg::SIZE_RESET;
      cfg_ovw_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brf_pkg::CFG_SIZE:      cfg_size_r <= cfg_wdata;
        brf_pkg::CFG_OVERWRITE: cfg_ovw_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Byte store: write on push, read at head or peek when a beat is taken
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= wdata_r;
    end
    if (in_fire) begin
      rd_data_r <= (in_action == brf_pkg::ACT_PEEK) ? mem[peek_r] : mem[head_r];
    end
  end

  // Compute the effect of the held action
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    peek_nxt  = peek_r;
    fill_nxt  = fill_r;
    pleft_nxt = pleft_r;
    status_c  = brf_pkg::ST_DONE;
    rdata_c   = '0;
    drop_c    = 1'b0;
    mem_we    = 1'b0;
    unique case (act_r)
      brf_pkg::ACT_PUSH: begin
        if (fill_r >= rsize && !cfg_ovw_r) begin
          status_c = brf_pkg::ST_REFUSED;
        end else begin
          if (fill_r >= rsize) begin
            // Drop the oldest byte and pull peek back to the new head
            head_nxt  = ring_next(head_r, rsize);
            peek_nxt  = head_nxt;
            pleft_nxt = fill_r;
            drop_c    = 1'b1;
          end else begin
            fill_nxt  = fill_r + brf_pkg::CNT_W'(1);
            pleft_nxt = pleft_r + brf_pkg::CNT_W'(1);
          end
          tail_nxt = ring_next(tail_r, rsize);
          mem_we   = exec_go;
        end
      end
      brf_pkg::ACT_POP: begin
        if (fill_r == '0) begin
          status_c = brf_pkg::ST_REFUSED;
        end else begin
          rdata_c   = rd_data_r;
          head_nxt  = ring_next(head_r, rsize);
          fill_nxt  = fill_r - brf_pkg::CNT_W'(1);
          peek_nxt  = head_nxt;
          pleft_nxt = fill_nxt;
        end
      end
      brf_pkg::ACT_PEEK: begin
        if (pleft_r == '0) begin
          status_c = brf_pkg::ST_REFUSED;
        end else begin
          rdata_c   = rd_data_r;
          peek_nxt  = ring_next(peek_r, rsize);
          pleft_nxt = pleft_r - brf_pkg::CNT_W'(1);
        end
      end
      brf_pkg::ACT_REWIND: begin
        peek_nxt  = head_r;
        pleft_nxt = fill_r;
      end
      brf_pkg::ACT_COMMIT: begin
        head_nxt = peek_r;
        fill_nxt = pleft_r;
      end
      brf_pkg::ACT_SETOFF: begin
        status_c  = clamp_r ? brf_pkg::ST_CLAMPED : brf_pkg::ST_DONE;
        peek_nxt  = PTR_W'(mod_rem);
        pleft_nxt = fill_r - off_r;
      end
      brf_pkg::ACT_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        peek_nxt  = '0;
        fill_nxt  = '0;
        pleft_nxt = '0;
      end
      default: ;
    endcase
  end

  // Ring pointers and counts: update when the held action completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      peek_r  <= '0;
      fill_r  <= '0;
      pleft_r <= '0;
    end else if (exec_go) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      peek_r  <= peek_nxt;
      fill_r  <= fill_nxt;
      pleft_r <= pleft_nxt;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Load the output register on completion, drop it once taken
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            act_r   <= brf_pkg::brf_action_t'(in_action);
            wdata_r <= in_write_data;
            off_r   <= off_eff;
            clamp_r <= off_over;
            last_r  <= in_request_last;
            state_r <= mod_start ? S_MOD : S_EXEC;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            out_status_r <= status_c;
            out_rdata_r  <= rdata_c;
            out_drop_r   <= drop_c;
            out_fill_r   <= fill_nxt;
            out_pleft_r  <= pleft_nxt;
            out_peeked_r <= fill_nxt - pleft_nxt;
            out_last_r   <= last_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_data      = out_rdata_r;
  assign out_dropped_oldest = out_drop_r;
  assign out_fill_count     = out_fill_r;
  assign out_peek_remaining = out_pleft_r;
  assign out_peeked_count   = out_peeked_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  // Peek never runs past the bytes held
  a_pleft_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pleft_r <= fill_r)
    else $error("peek count exceeds fill level");

  // Fill never exceeds the largest usable ring size
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= brf_pkg::CNT_W'(DEPTH_CAP))
    else $error("fill level beyond ring capacity");

  // The remainder unit only finishes while the sequencer waits for it
  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder done outside wait state");

  // A completed action always leaves a result beat in the output register
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (out_valid_r && state_r == S_IDLE))
    else $error("completed action produced no result beat");

  // Store writes happen only for an accepted push
  a_write_push: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (exec_go && act_r == brf_pkg::ACT_PUSH && status_c == brf_pkg::ST_DONE))
    else $error("store write outside a push");
`endif

endmodule

`default_nettype wire

FILE: design/brf_mod_unit.sv
// Iterative remainder unit: dividend modulo divisor, one quotient bit per cycle.
// Uses brf_pkg for the count width.
`default_nettype none

module brf_mod_unit #(
  parameter int unsigned SUM_W = 17
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  [SUM_W-1:0]             dividend,
  input  wire  [brf_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [brf_pkg::CNT_W-1:0]    remainder
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic [SUM_W-1:0]            shift_r;
  logic [brf_pkg::CNT_W-1:0]   rem_r;
  logic [brf_pkg::CNT_W:0]     trial;
  logic [brf_pkg::CNT_W-1:0]   rem_nxt;

  // Bring down the next dividend bit and subtract the divisor when it fits
  always_comb begin
    trial = {rem_r, shift_r[SUM_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = brf_pkg::CNT_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[brf_pkg::CNT_W-1:0];
    end
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load on start, shift while busy, hold afterwards
  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= shift_r << 1;
      rem_r   <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: tb/brf_checker.sv
`timescale 1ns / 100ps
// Scoreboard for byte_ring_fifo_with_peek: follows the ring state from the
// accepted input beats and compares each result beat field by field.
// Depends on brf_pkg; counts failures and reports results still outstanding.
module brf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brf_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [brf_pkg::ACT_W-1:0]     in_action,
  input  logic [brf_pkg::DATA_W-1:0]    in_write_data,
  input  logic [brf_pkg::CNT_W-1:0]     in_offset_count,
  input  logic                          in_request_last,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [brf_pkg::STAT_W-1:0]    out_status,
  input  logic [brf_pkg::DATA_W-1:0]    out_read_data,
  input  logic                          out_dropped_oldest,
  input  logic [brf_pkg::CNT_W-1:0]     out_fill_count,
  input  logic [brf_pkg::CNT_W-1:0]     out_peek_remaining,
  input  logic [brf_pkg::CNT_W-1:0]     out_peeked_count,
  input  logic                          out_request_last,
  output int                            fail_count,
  output int                            pending
);

  localparam int RING_DEPTH = 256;

  typedef struct packed {
    logic [brf_pkg::STAT_W-1:0] status;
    logic [brf_pkg::DATA_W-1:0] read_data;
    logic                       dropped;
    logic [brf_pkg::CNT_W-1:0]  fill;
    logic [brf_pkg::CNT_W-1:0]  remaining;
    logic [brf_pkg::CNT_W-1:0]  peeked;
    logic                       last;
  } ring_result_t;

  // Shadow of the ring: store, pointers, counts and both registers
  logic [brf_pkg::DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [7:0]                 head_q;
  logic [7:0]                 tail_q;
  logic [7:0]                 peek_q;
  logic [brf_pkg::CNT_W-1:0]  fill_q;
  logic [brf_pkg::CNT_W-1:0]  left_q;
  logic [brf_pkg::CNT_W-1:0]  size_reg;
  logic                       overwrite_q;

  ring_result_t awaited_results[$];

  // Size 0 behaves as 1, anything past the store behaves as the full store
  function automatic logic [brf_pkg::CNT_W-1:0] live_size();
    if (size_reg == '0) return 9'd1;
    if (size_reg > 9'd256) return 9'd256;
    return size_reg;
  endfunction

  function automatic logic [7:0] wrap_next(input logic [7:0] idx);
    logic [brf_pkg::CNT_W-1:0] nxt;
    nxt = {1'b0, idx} + 9'd1;
    return (nxt >= live_size()) ? 8'd0 : nxt[7:0];
  endfunction

  // Apply one action to the shadow ring and return the result it should give
  function automatic ring_result_t apply_ring_action(
    input logic [brf_pkg::ACT_W-1:0]  act_bits,
    input logic [brf_pkg::DATA_W-1:0] wdata,
    input logic [brf_pkg::CNT_W-1:0]  offset,
    input logic                       last
  );
    ring_result_t              res;
    logic [brf_pkg::CNT_W-1:0] ring_len;
    logic [brf_pkg::CNT_W-1:0] ofs;
    logic [brf_pkg::CNT_W:0]   spot;
    res = '0;
    res.status = brf_pkg::ST_DONE;
    res.last = last;
    ring_len = live_size();
    ofs = offset;
    case (brf_pkg::brf_action_t'(act_bits))
      brf_pkg::ACT_PUSH: begin
        if (fill_q >= ring_len && !overwrite_q) begin
          res.status = brf_pkg::ST_REFUSED;
        end else begin
          // full with overwrite on: drop the oldest, peek back to head
          if (fill_q >= ring_len) begin
            head_q = wrap_next(head_q);
            fill_q = fill_q - 9'd1;
            peek_q = head_q;
            left_q = fill_q;
            res.dropped = 1'b1;
          end
          ring_mem[tail_q] = wdata;
          tail_q = wrap_next(tail_q);
          fill_q = fill_q + 9'd1;
          left_q = left_q + 9'd1;
        end
      end
      brf_pkg::ACT_POP: begin
        if (fill_q == '0) begin
          res.status = brf_pkg::ST_REFUSED;
        end else begin
          res.read_data = ring_mem[head_q];
          head_q = wrap_next(head_q);
          fill_q = fill_q - 9'd1;
          peek_q = head_q;
          left_q = fill_q;
        end
      end
      brf_pkg::ACT_PEEK: begin
        if (left_q == '0) begin
          res.status = brf_pkg::ST_REFUSED;
        end else begin
          res.read_data = ring_mem[peek_q];
          peek_q = wrap_next(peek_q);
          left_q = left_q - 9'd1;
        end
      end
      brf_pkg::ACT_REWIND: begin
        peek_q = head_q;
        left_q = fill_q;
      end
      brf_pkg::ACT_COMMIT: begin
        head_q = peek_q;
        fill_q = left_q;
      end
      brf_pkg::ACT_SETOFF: begin
        // clamp the offset to what the ring holds
        if (ofs > fill_q) begin
          ofs = fill_q;
          res.status = brf_pkg::ST_CLAMPED;
        end
        spot = ({2'b00, head_q} + {1'b0, ofs}) % {1'b0, ring_len};
        peek_q = spot[7:0];
        left_q = fill_q - ofs;
      end
      brf_pkg::ACT_CLEAR: begin
        head_q = '0;
        tail_q = '0;
        peek_q = '0;
        fill_q = '0;
        left_q = '0;
      end
      default: begin
      end
    endcase
    res.fill = fill_q;
    res.remaining = left_q;
    res.peeked = fill_q - left_q;
    return res;
  endfunction

  task automatic check_field(
    input string                     name,
    input logic [brf_pkg::CNT_W-1:0] want_v,
    input logic [brf_pkg::CNT_W-1:0] got_v
  );
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Track configuration, check result beats, predict from input beats
  always @(posedge clk) begin : ring_track
    ring_result_t want;
    if (!rst_n) begin
      head_q = '0;
      tail_q = '0;
      peek_q = '0;
      fill_q = '0;
      left_q = '0;
      size_reg = brf_pkg::SIZE_RESET;
      overwrite_q = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == brf_pkg::CFG_SIZE) size_reg = cfg_wdata;
        else if (cfg_index == brf_pkg::CFG_OVERWRITE) overwrite_q = cfg_wdata[0];
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, got status %0d",
                   $time, out_status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 9'(want.status), 9'(out_status));
          check_field("read_data", 9'(want.read_data), 9'(out_read_data));
          check_field("dropped_oldest", 9'(want.dropped), 9'(out_dropped_oldest));
          check_field("fill_count", want.fill, out_fill_count);
          check_field("peek_remaining", want.remaining, out_peek_remaining);
          check_field("peeked_count", want.peeked, out_peeked_count);
          check_field("last", 9'(want.last), 9'(out_request_last));
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_ring_action(in_action, in_write_data,
                                                    in_offset_count, in_request_last));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the byte_ring_fifo_with_peek testbench: clock, reset, register
// writes, input beats and result backpressure; verdict from brf_checker.
// Depends on brf_pkg, byte_ring_fifo_with_peek and brf_checker.
module tb_top;

  localparam logic [brf_pkg::ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 30;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SEGMENT_BEATS    = 42;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          cfg_we          = 1'b0;
  logic [brf_pkg::CFG_IDX_W-1:0] cfg_index       = brf_pkg::CFG_SIZE;
  logic [brf_pkg::CNT_W-1:0]     cfg_wdata       = '0;
  logic                          in_valid        = 1'b0;
  logic [brf_pkg::ACT_W-1:0]     in_action       = brf_pkg::ACT_PUSH;
  logic [brf_pkg::DATA_W-1:0]    in_write_data   = '0;
  logic [brf_pkg::CNT_W-1:0]     in_offset_count = '0;
  logic                          in_request_last = 1'b0;
  logic                          out_ready       = 1'b0;

  logic                          in_ready;
  logic                          out_valid;
  logic [brf_pkg::STAT_W-1:0]    out_status;
  logic [brf_pkg::DATA_W-1:0]    out_read_data;
  logic                          out_dropped_oldest;
  logic [brf_pkg::CNT_W-1:0]     out_fill_count;
  logic [brf_pkg::CNT_W-1:0]     out_peek_remaining;
  logic [brf_pkg::CNT_W-1:0]     out_peeked_count;
  logic                          out_last;

  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int          cycle_count    = 0;
  int          fail_count;
  int          pending;

  always #1 clk = ~clk;

  byte_ring_fifo_with_peek dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_write_data      (in_write_data),
    .in_offset_count    (in_offset_count),
    .in_request_last    (in_request_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_data      (out_read_data),
    .out_dropped_oldest (out_dropped_oldest),
    .out_fill_count     (out_fill_count),
    .out_peek_remaining (out_peek_remaining),
    .out_peeked_count   (out_peeked_count),
    .out_last           (out_last)
  );

  brf_checker ring_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_write_data      (in_write_data),
    .in_offset_count    (in_offset_count),
    .in_request_last    (in_request_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_data      (out_read_data),
    .out_dropped_oldest (out_dropped_oldest),
    .out_fill_count     (out_fill_count),
    .out_peek_remaining (out_peek_remaining),
    .out_peeked_count   (out_peeked_count),
    .out_request_last   (out_last),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random backpressure, plus one long hold on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one beat, idling first at random, and hold it until taken
  task automatic send_beat(
    input logic [brf_pkg::ACT_W-1:0]  act,
    input logic [brf_pkg::DATA_W-1:0] data,
    input logic [brf_pkg::CNT_W-1:0]  ofs,
    input logic                       last
  );
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_write_data   <= data;
    in_offset_count <= ofs;
    in_request_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait for every outstanding result, then let it settle
  task automatic drain_ring();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [brf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [brf_pkg::CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [brf_pkg::CNT_W-1:0] pick_offset();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return brf_pkg::CNT_W'($urandom_range(8));
    if (roll < 85) return brf_pkg::CNT_W'($urandom_range(511));
    return 9'd256;
  endfunction

  // Ring sizes per segment: tiny rings, the full store and out-of-range codes
  function automatic logic [brf_pkg::CNT_W-1:0] size_for_segment(input int seg);
    case (seg)
      0: return 9'd1;
      1: return 9'd256;
      2: return 9'd3;
      3: return 9'd0;
      4: return 9'd16;
      5: return 9'd511;
      6: return 9'd2;
      7: return brf_pkg::CNT_W'($urandom_range(1, 256));
      default: return 9'd5;
    endcase
  endfunction

  // Bursts of one flavor each, closed by request_last; a few are pure noise
  task automatic run_segment(input int n_beats);
    int                        sent;
    int                        len;
    int                        kind;
    int unsigned               roll;
    logic [brf_pkg::ACT_W-1:0] act;
    logic                      last;
    sent = 0;
    while (sent < n_beats) begin
      len  = $urandom_range(2, 12);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(99);
        last = (i == len - 1);
        if (kind < 4) begin
          act = (roll < 85) ? brf_pkg::ACT_PUSH :
                (roll < 93) ? brf_pkg::ACT_PEEK : brf_pkg::ACT_POP;
        end else if (kind < 6) begin
          act = (roll < 75) ? brf_pkg::ACT_POP :
                (roll < 95) ? brf_pkg::ACT_PUSH : brf_pkg::ACT_CLEAR;
        end else if (kind < 9) begin
          act = (roll < 45) ? brf_pkg::ACT_PEEK : (roll < 60) ? brf_pkg::ACT_SETOFF :
                (roll < 75) ? brf_pkg::ACT_COMMIT : (roll < 87) ? brf_pkg::ACT_REWIND :
                brf_pkg::ACT_PUSH;
        end else begin
          act  = brf_pkg::ACT_W'($urandom_range(7));
          last = 1'($urandom_range(1));
        end
        send_beat(act, brf_pkg::DATA_W'($urandom_range(255)), pick_offset(), last);
        sent++;
      end
    end
  endtask

  // Clear, reconfigure while idle, then run random bursts
  task automatic run_phase(
    input int unsigned tx_pct,
    input int unsigned rx_pct,
    input int          first_seg,
    input logic        with_hold
  );
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int s = 0; s < 3; s++) begin
      send_beat(brf_pkg::ACT_CLEAR, 8'h00, 9'd0, 1'b1);
      drain_ring();
      write_reg(brf_pkg::CFG_SIZE, size_for_segment(first_seg + s));
      write_reg(brf_pkg::CFG_OVERWRITE, brf_pkg::CNT_W'((first_seg + s) % 2));
      if (with_hold && s == 0) long_hold_req = 1'b1;
      run_segment(SEGMENT_BEATS);
    end
  endtask

  task automatic directed_checks();
    // empty ring: refusals, unused code, commit and offset on nothing
    send_beat(brf_pkg::ACT_POP, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 1'b0);
    send_beat(ACT_UNUSED, 8'hFF, 9'd0, 1'b1);
    send_beat(brf_pkg::ACT_COMMIT, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_SETOFF, 8'hFF, 9'd511, 1'b1);
    // data extremes, read ahead, offset clamp, rewind and commit
    send_beat(brf_pkg::ACT_PUSH, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_PUSH, 8'hFF, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_PUSH, 8'hA5, 9'd0, 1'b1);
    send_beat(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_SETOFF, 8'h00, 9'd1, 1'b0);
    send_beat(brf_pkg::ACT_SETOFF, 8'h00, 9'd256, 1'b0);
    send_beat(brf_pkg::ACT_REWIND, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_COMMIT, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_POP, 8'h00, 9'd0, 1'b1);
    send_beat(brf_pkg::ACT_CLEAR, 8'h00, 9'd0, 1'b1);
    drain_ring();
    // fill a small ring, refuse when full, then shrink it while holding data
    write_reg(brf_pkg::CFG_SIZE, 9'd4);
    for (int i = 0; i < 4; i++) begin
      send_beat(brf_pkg::ACT_PUSH, brf_pkg::DATA_W'($urandom_range(255)), 9'd0, 1'b0);
    end
    send_beat(brf_pkg::ACT_PUSH, 8'h5A, 9'd0, 1'b1);
    drain_ring();
    write_reg(brf_pkg::CFG_SIZE, 9'd2);
    send_beat(brf_pkg::ACT_POP, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_PUSH, 8'h3C, 9'd0, 1'b1);
    drain_ring();
    // overwrite drops the oldest byte
    write_reg(brf_pkg::CFG_OVERWRITE, 9'd1);
    send_beat(brf_pkg::ACT_PUSH, 8'hC3, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_POP, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_CLEAR, 8'h00, 9'd0, 1'b1);
    drain_ring();
    // size code 0 acts as a one-byte ring
    write_reg(brf_pkg::CFG_SIZE, 9'd0);
    send_beat(brf_pkg::ACT_PUSH, 8'h81, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_PUSH, 8'h7E, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_POP, 8'h00, 9'd0, 1'b0);
    send_beat(brf_pkg::ACT_POP, 8'h00, 9'd0, 1'b1);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    run_phase(32, 56, 0, 1'b0);
    run_phase(56, 32, 3, 1'b0);
    run_phase(0, 0, 6, 1'b1);
    drain_ring();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
